// ===== hdl/kdcm_pkg.sv =====
// Shared constants, types and register codes for the knob deadband and CC merge block.
package kdcm_pkg;

  // Slot and field geometry
  localparam int SLOTS       = 8;
  localparam int SLOT_W      = 3;
  localparam int SAMPLE_BITS = 10;
  localparam int IN_SAMPLE_W = 10;
  localparam int THR_W       = 10;
  localparam int VAL_W       = 7;
  localparam int CC_W        = 7;
  localparam int MAP_BYTE_W  = 8;
  localparam int MAP_W       = SLOTS * MAP_BYTE_W;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 64;

  // Deadband arithmetic: enough headroom for prev + threshold + prev/50
  localparam int BAND_W      = ((SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W) + 2;
  // floor(x/50) as (x * 1311) >> 16, exact for x below 2^12
  localparam int DIV50_RECIP_W = 11;
  localparam logic [DIV50_RECIP_W-1:0] DIV50_RECIP = 11'd1311;
  localparam int DIV50_SHIFT = 16;
  // Scaling to 0..126
  localparam logic [VAL_W-1:0] SCALE_MUL = 7'd127;

  // Register reset values
  localparam logic [THR_W-1:0] THR_RESET   = 10'd4;
  localparam logic [MAP_W-1:0] MAP_RESET   = '1;
  localparam logic [SLOTS-1:0] KNOB_RESET  = '0;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_JITTER  = 2'd0,
    REG_CC_MAP  = 2'd1,
    REG_KNOB_EN = 2'd2
  } cfg_reg_t;

  // Knob unit control bundle
  typedef struct packed {
    logic [THR_W-1:0] threshold;
    logic [SLOTS-1:0] enable;
    logic             clear;
    logic [SLOTS-1:0] clear_mask;
  } knob_ctl_t;

  // Work handed to the result sequencer: one bit per slot to report
  typedef struct packed {
    logic [SLOTS-1:0] mask;
    logic [VAL_W-1:0] value;
    logic             from_midi;
  } job_t;

endpackage

// ===== hdl/kdcm_if.sv =====
// Channel interfaces: input items, result items and configuration writes.
interface kdcm_item_if;
  import kdcm_pkg::*;
  logic                   valid;
  logic                   ready;
  logic                   mode;
  logic [SLOT_W-1:0]      knob_slot;
  logic [IN_SAMPLE_W-1:0] sample;
  logic [CC_W-1:0]        cc_number;
  logic [VAL_W-1:0]       cc_value;
  modport source (output valid, mode, knob_slot, sample, cc_number, cc_value, input ready);
  modport sink   (input valid, mode, knob_slot, sample, cc_number, cc_value, output ready);
endinterface

interface kdcm_result_if;
  import kdcm_pkg::*;
  logic              valid;
  logic              ready;
  logic [SLOT_W-1:0] slot;
  logic [VAL_W-1:0]  value;
  logic              from_midi;
  logic              last;
  modport source (output valid, slot, value, from_midi, last, input ready);
  modport sink   (input valid, slot, value, from_midi, last, output ready);
endinterface

interface kdcm_cfg_if;
  import kdcm_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/kdcm_knob_unit.sv =====
// Per-slot knob deadband filter and 0..126 scaler with its slot state.
module kdcm_knob_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        fire,
  input  logic [kdcm_pkg::SLOT_W-1:0] slot,
  input  logic [kdcm_pkg::SAMPLE_BITS-1:0] cur,
  input  kdcm_pkg::knob_ctl_t         ctl,
  output logic                        emit,
  output logic [kdcm_pkg::VAL_W-1:0]  scaled
);
  import kdcm_pkg::*;

  logic [SAMPLE_BITS-1:0] accepted_sample [SLOTS];
  logic [VAL_W-1:0]       scaled_knob [SLOTS];

  logic                              slot_on;
  logic [SAMPLE_BITS-1:0]            prev;
  logic [SAMPLE_BITS+DIV50_RECIP_W-1:0] div_prod;
  logic [BAND_W-1:0]                 band;
  logic [BAND_W-1:0]                 prev_x;
  logic [BAND_W-1:0]                 cur_x;
  logic                              outside;
  logic [SAMPLE_BITS+VAL_W-1:0]      scale_prod;
  logic                              upd;

  // Deadband test against the last accepted sample of the slot
  always_comb begin
    slot_on    = ({1'b0, slot} < (SLOT_W+1)'(SLOTS)) && ctl.enable[slot];
    prev       = accepted_sample[slot];
    div_prod   = (SAMPLE_BITS+DIV50_RECIP_W)'(prev) * (SAMPLE_BITS+DIV50_RECIP_W)'(DIV50_RECIP);
    band       = BAND_W'(ctl.threshold) + BAND_W'(div_prod >> DIV50_SHIFT);
    prev_x     = BAND_W'(prev);
    cur_x      = BAND_W'(cur);
    outside    = (cur_x > prev_x + band) || (cur_x + band < prev_x);
    scale_prod = (SAMPLE_BITS+VAL_W)'(cur) * (SAMPLE_BITS+VAL_W)'(SCALE_MUL);
    scaled     = scale_prod[SAMPLE_BITS +: VAL_W];
    upd        = fire && slot_on && outside;
    emit       = slot_on && outside && (scaled != scaled_knob[slot]);
  end

  // Slot state: cleared on reset and for every slot set in a knob enable write
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        accepted_sample[i] <= '0;
        scaled_knob[i]     <= '0;
      end
    end else if (ctl.clear) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (ctl.clear_mask[i]) begin
          accepted_sample[i] <= '0;
          scaled_knob[i]     <= '0;
        end
      end
    end else if (upd) begin
      accepted_sample[slot] <= cur;
      scaled_knob[slot]     <= scaled;
    end
  end

`ifndef SYNTHESIS
  // An accepted sample becomes the new deadband center
  a_center_update: assert property (@(posedge clk) disable iff (rst)
    upd && !ctl.clear |=> accepted_sample[$past(slot)] == $past(cur))
    else $error("accepted sample not stored");
  // A reported value always differs from the slot's stored scaled value
  a_emit_changed: assert property (@(posedge clk) disable iff (rst)
    fire && emit |-> upd && scaled != scaled_knob[slot])
    else $error("knob result without a change");
`endif

endmodule

// ===== hdl/kdcm_emitter.sv =====
// Result sequencer: walks a slot mask lowest first into the output register.
module kdcm_emitter (
  input  logic               clk,
  input  logic               rst,
  input  logic               job_valid,
  input  kdcm_pkg::job_t     job,
  output logic               job_ready,
  kdcm_result_if.source      result
);
  import kdcm_pkg::*;

  logic [SLOTS-1:0]  pend;
  logic [VAL_W-1:0]  pend_value;
  logic              pend_midi;

  logic [SLOTS-1:0]  lowbit;
  logic [SLOTS-1:0]  rest;
  logic [SLOT_W-1:0] sel;
  logic              out_load;
  logic              emit;

  // Pick the lowest pending slot
  always_comb begin
    lowbit = pend & (~pend + SLOTS'(1));
    rest   = pend & ~lowbit;
    sel    = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (lowbit[i]) sel = SLOT_W'(i);
    end
    out_load  = !result.valid || result.ready;
    emit      = (pend != '0) && out_load;
    job_ready = (pend == '0) || (emit && (rest == '0));
  end

  // Pending slot mask
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else if (job_valid && job_ready) begin
      pend <= job.mask;
    end else if (emit) begin
      pend <= rest;
    end
  end

  always_ff @(posedge clk) begin
    if (job_valid && job_ready) begin
      pend_value <= job.value;
      pend_midi  <= job.from_midi;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (out_load) begin
      result.valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result.slot      <= sel;
      result.value     <= pend_value;
      result.from_midi <= pend_midi;
      result.last      <= (rest == '0);
    end
  end

`ifndef SYNTHESIS
  // A knob update is always the only result of its item
  a_knob_last: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.from_midi |-> result.last)
    else $error("knob result without last");
  // No new job while more than one slot is still to be reported
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    $countones(pend) > 1 |-> !job_ready)
    else $error("job taken over pending results");
`endif

endmodule

// ===== hdl/knob_deadband_and_cc_merge_top.sv =====
// Top level: input register, configuration registers, CC matching, knob unit and sequencer.
// Path: input register, job register and output register, registered in turn.
// Throughput: one item per cycle while each item yields at most one result and the
//   output is not stalled; a CC beat matching n slots holds the sequencer, one result
//   per cycle while the output is not stalled.
// Reset: synchronous, clears control state, slot state and registers to their defaults.
module knob_deadband_and_cc_merge_top (
  input  logic          clk,
  input  logic          rst,
  kdcm_item_if.sink     item,
  kdcm_result_if.source result,
  kdcm_cfg_if.sink      cfg
);
  import kdcm_pkg::*;

  // Configuration registers
  logic [THR_W-1:0] jitter_threshold;
  logic [MAP_W-1:0] cc_map;
  logic [SLOTS-1:0] knob_enable_mask;

  // Input register
  logic                   in_vld;
  logic                   in_mode;
  logic [SLOT_W-1:0]      in_slot;
  logic [IN_SAMPLE_W-1:0] in_sample;
  logic [CC_W-1:0]        in_cc_num;
  logic [VAL_W-1:0]       in_cc_val;

  logic             cfg_we;
  logic             job_ready;
  logic             proc_fire;
  logic [SLOTS-1:0] hit;
  logic             knob_emit;
  logic [VAL_W-1:0] knob_value;
  knob_ctl_t        knob_ctl;
  job_t             job;

  assign cfg.ready  = 1'b1;
  assign cfg_we     = cfg.valid && cfg.ready;
  assign proc_fire  = in_vld && job_ready;
  assign item.ready = !in_vld || job_ready;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      jitter_threshold <= THR_RESET;
      cc_map           <= MAP_RESET;
      knob_enable_mask <= KNOB_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_JITTER:  jitter_threshold <= cfg.data[THR_W-1:0];
        REG_CC_MAP:  cc_map           <= cfg.data[MAP_W-1:0];
        REG_KNOB_EN: knob_enable_mask <= cfg.data[SLOTS-1:0];
        default:     ;
      endcase
    end
  end

  // Input beat capture
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (item.ready) begin
      in_vld <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      in_mode   <= item.mode;
      in_slot   <= item.knob_slot;
      in_sample <= item.sample;
      in_cc_num <= item.cc_number;
      in_cc_val <= item.cc_value;
    end
  end

  // Controller number match per slot; a set top bit leaves the slot unmapped
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      hit[i] = !cc_map[i*MAP_BYTE_W + MAP_BYTE_W - 1] &&
               (cc_map[i*MAP_BYTE_W +: CC_W] == in_cc_num);
    end
  end

  // Knob path
  always_comb begin
    knob_ctl.threshold  = jitter_threshold;
    knob_ctl.enable     = knob_enable_mask;
    knob_ctl.clear      = cfg_we && (cfg.index == REG_KNOB_EN);
    knob_ctl.clear_mask = cfg.data[SLOTS-1:0];
  end

  kdcm_knob_unit u_knob (
    .clk    (clk),
    .rst    (rst),
    .fire   (proc_fire && !in_mode),
    .slot   (in_slot),
    .cur    (SAMPLE_BITS'(in_sample)),
    .ctl    (knob_ctl),
    .emit   (knob_emit),
    .scaled (knob_value)
  );

  // Job for the sequencer
  always_comb begin
    if (in_mode) begin
      job.mask      = hit;
      job.value     = in_cc_val;
      job.from_midi = 1'b1;
    end else begin
      job.mask      = knob_emit ? (SLOTS'(1) << in_slot) : '0;
      job.value     = knob_value;
      job.from_midi = 1'b0;
    end
  end

  kdcm_emitter u_emit (
    .clk       (clk),
    .rst       (rst),
    .job_valid (proc_fire),
    .job       (job),
    .job_ready (job_ready),
    .result    (result)
  );

`ifndef SYNTHESIS
  // A stalled input register keeps its beat
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_vld && !job_ready |=> in_vld && $stable(in_sample) && $stable(in_mode))
    else $error("input register lost a stalled beat");
`endif

endmodule
